FILE: rtl/frame_packet_loss_tracker_top_assert.svh
// Assertion macros shared by the frame packet loss tracker RTL.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef FRAME_PACKET_LOSS_TRACKER_TOP_ASSERT_SVH
`define FRAME_PACKET_LOSS_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked property, masked while reset is asserted
`define FPLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication built on the macro above
`define FPLT_ASSERT_IMPL(lbl, ante, cons, msg) \
    `FPLT_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define FPLT_ASSERT(lbl, prop, msg)
`define FPLT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/fplt_pkg.sv
// Package for the frame packet loss tracker: field widths, codes, command word.
// No dependencies; imported by every module of the block.
`default_nettype none

package fplt_pkg;

    localparam int FRAME_PACKETS_DEF = 128;
    localparam int FRAME_W           = 64;
    localparam int SLOT_W            = 7;
    localparam int COUNT_W           = 8;
    localparam int ORDER_W           = 2;
    localparam int QUEUE_DEPTH       = 2;

    // Slot order register codes; the unused code behaves as ascending
    localparam logic [ORDER_W-1:0] ORDER_INTERLEAVED = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_DESCENDING  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_ASCENDING   = 2'd2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PLACE = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_DROP  = 2'd2
    } kind_t;

    // Which result of a command the back end is emitting
    typedef enum logic [1:0] {
        PH_CLOSE_OLD = 2'd0,
        PH_PLACE     = 2'd1,
        PH_CLOSE_NEW = 2'd2,
        PH_DROP      = 2'd3
    } phase_t;

    // Classified packet, passed from front end to back end through the queue
    typedef struct packed {
        logic               drop;
        logic               close_old;
        logic               close_new;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] place_missed;
        logic [FRAME_W-1:0] old_frame;
        logic [COUNT_W-1:0] old_missed;
        logic [COUNT_W-1:0] old_valid;
        logic               old_full;
        logic [COUNT_W-1:0] new_valid;
        logic               new_full;
    } cmd_t;

    // Clamp an internal count to the 8-bit result field
    function automatic logic [COUNT_W-1:0] sat8(input logic [15:0] v);
        logic [COUNT_W-1:0] r;
        r = (v > 16'd255) ? 8'hFF : v[COUNT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/frame_packet_loss_tracker_top.sv
// Top level of the frame packet loss tracker: front end, command queue, back end.
// Depends on fplt_pkg, fplt_front, fplt_queue and fplt_back.
//
// Usage:
//   in channel (in_valid/in_ready): one word per received packet, carrying
//   frame_no and pkt_slot. out channel (out_valid/out_ready): result
//   words kind, frame_id, slot, missed_before, valid_count, frame_full, last;
//   last marks the final result of one packet. cfg channel (cfg_valid/
//   cfg_ready/cfg_data) writes slot_order; cfg_ready is always high, write it
//   only while the block is idle.
//   An accepted packet word is written into the queue; with the output
//   register free, its first result is then loaded into the output register.
//   A packet yields one result, two when it closes the previous frame or
//   ends its own, three when both. The front end takes one word per cycle
//   while the queue has room; the back end sends one result per cycle while
//   out_ready is high: one packet per cycle when each gives one result.
//   Reset clears slot_order to interleaved, closes any frame and empties the
//   two-entry queue. When the receiver stalls, the output register holds its
//   word, the queue fills and in_ready drops once both queue entries are taken.
`default_nettype none

module frame_packet_loss_tracker_top
    import fplt_pkg::*;
#(
    parameter int FRAME_PACKETS = FRAME_PACKETS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [ORDER_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FRAME_W-1:0] frame_no,
    input  wire logic [SLOT_W-1:0]  pkt_slot,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              kind,
    output logic [FRAME_W-1:0]      frame_id,
    output logic [SLOT_W-1:0]       slot,
    output logic [COUNT_W-1:0]      missed_before,
    output logic [COUNT_W-1:0]      valid_count,
    output logic                    frame_full,
    output logic                    last
);

    logic cmd_push;
    cmd_t cmd;
    logic queue_full;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // Classification and frame state
    fplt_front #(
        .FRAME_PACKETS (FRAME_PACKETS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_no      (frame_no),
        .pkt_slot      (pkt_slot),
        .queue_full    (queue_full),
        .cmd_push      (cmd_push),
        .cmd           (cmd)
    );

    // Command queue
    fplt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Result expansion and output register
    fplt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .frame_id      (frame_id),
        .slot          (slot),
        .missed_before (missed_before),
        .valid_count   (valid_count),
        .frame_full    (frame_full),
        .last          (last)
    );

endmodule

`default_nettype wire

FILE: rtl/fplt_front.sv
// Front end: holds the slot order register and the open-frame state, classifies
// each packet word into a command word. Depends on fplt_pkg.
`default_nettype none

module fplt_front
    import fplt_pkg::*;
#(
    parameter int FRAME_PACKETS = FRAME_PACKETS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [ORDER_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FRAME_W-1:0] frame_no,
    input  wire logic [SLOT_W-1:0]  pkt_slot,
    input  wire logic               queue_full,
    output logic                    cmd_push,
    output cmd_t                    cmd
);

    localparam int CW   = $clog2(FRAME_PACKETS + 1);
    localparam int IW   = $clog2(FRAME_PACKETS + 256);
    localparam int HALF = FRAME_PACKETS / 2;

    localparam logic [IW-1:0] F_I       = IW'(FRAME_PACKETS);
    localparam logic [IW-1:0] LAST_I    = IW'(FRAME_PACKETS - 1);
    localparam logic [IW-1:0] HALF_I    = IW'(HALF);
    localparam logic [IW-1:0] HALF_M1_I = IW'(HALF - 1);
    localparam logic [CW-1:0] F_C       = CW'(FRAME_PACKETS);
    localparam logic [CW-1:0] LAST_C    = CW'(FRAME_PACKETS - 1);

    logic [ORDER_W-1:0] slot_order_reg;
    logic [FRAME_W-1:0] open_frame_reg;
    logic               active_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      good_reg;

    logic [IW-1:0] n_ext;
    logic [IW-1:0] lo_diff;
    logic [IW-1:0] hi_diff;
    logic [IW-1:0] idx;
    logic [CW-1:0] idx_c;
    logic          idx_ok;
    logic          same;
    logic          change;
    logic          late;
    logic          drop;
    logic          closes;
    logic [CW-1:0] base_pos;
    logic [CW-1:0] base_good;
    logic [CW-1:0] new_good;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign cmd_push  = in_valid && in_ready;

    // Slot number to position in the expected order
    assign n_ext   = IW'(pkt_slot);
    assign lo_diff = HALF_M1_I - n_ext;
    assign hi_diff = n_ext - HALF_I;

    always_comb
    begin
        unique case (slot_order_reg)
            ORDER_DESCENDING:
            begin
                idx = (n_ext > LAST_I) ? F_I : (LAST_I - n_ext);
            end
            ORDER_INTERLEAVED:
            begin
                if (n_ext < HALF_I)
                    idx = {lo_diff[IW-2:0], 1'b0};
                else
                    idx = {hi_diff[IW-2:0], 1'b1};
            end
            default:
            begin
                idx = n_ext;
            end
        endcase
    end

    // Classification against the open frame
    assign idx_ok    = idx < F_I;
    assign idx_c     = idx[CW-1:0];
    assign same      = active_reg && (frame_no == open_frame_reg);
    assign change    = active_reg && !same;
    assign late      = same && (idx_c < pos_reg);
    assign drop      = !idx_ok || late;
    assign closes    = idx_c == LAST_C;
    assign base_pos  = same ? pos_reg : '0;
    assign base_good = same ? good_reg : '0;
    assign new_good  = base_good + CW'(1);

    // Command word
    always_comb
    begin
        cmd.drop         = drop;
        cmd.close_old    = !drop && change;
        cmd.close_new    = !drop && closes;
        cmd.frame        = frame_no;
        cmd.slot         = pkt_slot;
        cmd.place_missed = sat8(16'(idx_c - base_pos));
        cmd.old_frame    = open_frame_reg;
        cmd.old_missed   = sat8(16'(F_C - pos_reg));
        cmd.old_valid    = sat8(16'(good_reg));
        cmd.old_full     = good_reg == F_C;
        cmd.new_valid    = sat8(16'(new_good));
        cmd.new_full     = new_good == F_C;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_order_reg <= ORDER_INTERLEAVED;
        else if (cfg_valid && cfg_ready)
            slot_order_reg <= cfg_data;
    end

    // Open-frame state; the last slot of the order closes the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_frame_reg <= '0;
            active_reg     <= 1'b0;
            pos_reg        <= '0;
            good_reg       <= '0;
        end
        else if (cmd_push && !drop)
        begin
            open_frame_reg <= frame_no;
            if (closes)
            begin
                active_reg <= 1'b0;
                pos_reg    <= '0;
                good_reg   <= '0;
            end
            else
            begin
                active_reg <= 1'b1;
                pos_reg    <= idx_c + CW'(1);
                good_reg   <= new_good;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fplt_queue.sv
// Short command queue between front end and back end.
// Depends on fplt_pkg for the command word type and depth.
`default_nettype none

module fplt_queue
    import fplt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_P = PW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] DEPTH_N = NW'(QUEUE_DEPTH);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full       = count_reg == DEPTH_N;
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Entry storage; cleared so an empty head decodes to a known phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                entry_reg[i] <= '0;
        end
        else if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + NW'(1);
            else if (pop && !push)
                count_reg <= count_reg - NW'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fplt_back.sv
// Back end: expands each command word into one to three result words and holds
// them in the output register. Depends on fplt_pkg and the assertion header.
`default_nettype none
`include "frame_packet_loss_tracker_top_assert.svh"

module fplt_back
    import fplt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire cmd_t                head_cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               kind,
    output logic [FRAME_W-1:0]       frame_id,
    output logic [SLOT_W-1:0]        slot,
    output logic [COUNT_W-1:0]       missed_before,
    output logic [COUNT_W-1:0]       valid_count,
    output logic                     frame_full,
    output logic                     last
);

    phase_t             ph_reg;
    phase_t             ph_next;
    logic               started_reg;
    phase_t             cur_ph;
    logic               is_last;
    logic               load;

    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COUNT_W-1:0] missed_reg;
    logic [COUNT_W-1:0] valid_reg;
    logic               full_reg;
    logic               last_reg;

    kind_t              kind_next;
    logic [FRAME_W-1:0] frame_next;
    logic [SLOT_W-1:0]  slot_next;
    logic [COUNT_W-1:0] missed_next;
    logic [COUNT_W-1:0] valid_next;
    logic               full_next;

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && is_last;

    // Current phase: a fresh command starts at its first result
    always_comb
    begin
        if (started_reg)
            cur_ph = ph_reg;
        else if (head_cmd.drop)
            cur_ph = PH_DROP;
        else if (head_cmd.close_old)
            cur_ph = PH_CLOSE_OLD;
        else
            cur_ph = PH_PLACE;
    end

    // Next phase
    always_comb
    begin
        unique case (cur_ph)
            PH_CLOSE_OLD: ph_next = PH_PLACE;
            PH_PLACE:     ph_next = PH_CLOSE_NEW;
            default:      ph_next = PH_DROP;
        endcase
    end

    // Result word for the current phase
    always_comb
    begin
        kind_next   = KIND_PLACE;
        frame_next  = head_cmd.frame;
        slot_next   = '0;
        missed_next = '0;
        valid_next  = '0;
        full_next   = 1'b0;
        is_last     = 1'b1;
        unique case (cur_ph)
            PH_CLOSE_OLD:
            begin
                kind_next   = KIND_CLOSE;
                frame_next  = head_cmd.old_frame;
                missed_next = head_cmd.old_missed;
                valid_next  = head_cmd.old_valid;
                full_next   = head_cmd.old_full;
                is_last     = 1'b0;
            end
            PH_PLACE:
            begin
                slot_next   = head_cmd.slot;
                missed_next = head_cmd.place_missed;
                is_last     = !head_cmd.close_new;
            end
            PH_CLOSE_NEW:
            begin
                kind_next  = KIND_CLOSE;
                valid_next = head_cmd.new_valid;
                full_next  = head_cmd.new_full;
            end
            PH_DROP:
            begin
                kind_next = KIND_DROP;
                slot_next = head_cmd.slot;
            end
        endcase
    end

    // Phase tracking within a command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            ph_reg      <= PH_PLACE;
        end
        else if (load)
        begin
            started_reg <= !is_last;
            ph_reg      <= ph_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_PLACE;
            last_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else if (load)
        begin
            kind_reg <= kind_next;
            last_reg <= is_last;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg  <= frame_next;
            slot_reg   <= slot_next;
            missed_reg <= missed_next;
            valid_reg  <= valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign frame_id      = frame_reg;
    assign slot          = slot_reg;
    assign missed_before = missed_reg;
    assign valid_count   = valid_reg;
    assign frame_full    = full_reg;
    assign last          = last_reg;

    // Checks
    `FPLT_ASSERT_IMPL(a_drop_is_last, out_valid_reg && (kind_reg == KIND_DROP), last_reg, "drop result not last")
    `FPLT_ASSERT_IMPL(a_full_on_close, out_valid_reg && full_reg, kind_reg == KIND_CLOSE, "full flag off close")
    `FPLT_ASSERT_IMPL(a_mid_cmd_head, started_reg, head_valid, "command left queue mid-expansion")
    `FPLT_ASSERT(a_pop_gives_last, pop |=> (out_valid_reg && last_reg), "pop without last result")

endmodule

`default_nettype wire
